// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PAFM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");

// Check a property on every clock edge, reset included.
`define PAFM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: property failed");

`endif

// ===== rtl/pafm_pkg.sv =====
// Types, constants and helpers of the phase-angle motor firing block.
`default_nettype none
package pafm_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int SAMPLE_W        = 10;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;
  localparam int NUM_MODES       = 5;
  localparam int MODE_W          = 3;
  localparam int LED_W           = 5;
  localparam int BLINK_W         = 7;

  localparam logic [CFG_DATA_W-1:0] EMERG_DELAY = 16'd14002;
  localparam logic [BLINK_W-1:0]    BLINK_DARK  = 7'd90;
  localparam logic [BLINK_W-1:0]    BLINK_LIT   = 7'd10;

  localparam logic [MODE_W-1:0] MODE_MIN   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_START = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MAX   = 3'd4;

  localparam logic [NUM_MODES-1:0][CFG_DATA_W-1:0] DELAY_RESET =
    {16'd8962, 16'd10562, 16'd12162, 16'd13762, 16'd13562};
  localparam logic [CFG_DATA_W-1:0] PULSE_RESET      = 16'd42;
  localparam logic [CFG_DATA_W-1:0] RAMP_START_RESET = 16'd16962;
  localparam logic [CFG_DATA_W-1:0] RAMP_STEP_RESET  = 16'd200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_MODE_ZERO  = 3'd0,
    REG_DELAY_MODE_ONE   = 3'd1,
    REG_DELAY_MODE_TWO   = 3'd2,
    REG_DELAY_MODE_THREE = 3'd3,
    REG_DELAY_MODE_FOUR  = 3'd4,
    REG_PULSE_TICKS      = 3'd5,
    REG_RAMP_START_DELAY = 3'd6,
    REG_RAMP_STEP        = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_VPULSE   = 3'd1,
    PH_DELAY    = 3'd2,
    PH_GATE     = 3'd3,
    PH_EM_DELAY = 3'd4,
    PH_EM_PULSE = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    CMB_NONE  = 2'd0,
    CMB_PLUS  = 2'd1,
    CMB_MINUS = 2'd2
  } combo_t;

  typedef struct packed {
    logic [NUM_MODES-1:0][CFG_DATA_W-1:0] delay_mode;
    logic [CFG_DATA_W-1:0]                pulse_ticks;
    logic [CFG_DATA_W-1:0]                ramp_start_delay;
    logic [CFG_DATA_W-1:0]                ramp_step;
  } cfg_regs_t;

  typedef struct packed {
    logic                power_held;
    logic                plus_held;
    logic                minus_held;
    logic                emergency_stop;
    logic [SAMPLE_W-1:0] line_sample;
  } in_item_t;

  typedef struct packed {
    logic              gate_pulse;
    logic              voltage_pulse;
    logic [LED_W-1:0]  leds_lit;
    logic              powered_on;
    logic [MODE_W-1:0] mode_now;
    logic              ramping;
  } out_item_t;

  // Mode m lights LEDs 0..m.
  function automatic logic [LED_W-1:0] mode_leds(input logic [MODE_W-1:0] m);
    logic [LED_W-1:0] leds;
    case (m)
      3'd0:    leds = 5'b00001;
      3'd1:    leds = 5'b00011;
      3'd2:    leds = 5'b00111;
      3'd3:    leds = 5'b01111;
      default: leds = 5'b11111;
    endcase
    return leds;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pafm_cfg.sv =====
// Configuration register file of the firing block.
`default_nettype none
module pafm_cfg
  import pafm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_regs_t                  regs
);

  cfg_regs_t regs_r;

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.delay_mode       <= DELAY_RESET;
      regs_r.pulse_ticks      <= PULSE_RESET;
      regs_r.ramp_start_delay <= RAMP_START_RESET;
      regs_r.ramp_step        <= RAMP_STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_DELAY_MODE_ZERO:  regs_r.delay_mode[0]     <= cfg_wdata;
        REG_DELAY_MODE_ONE:   regs_r.delay_mode[1]     <= cfg_wdata;
        REG_DELAY_MODE_TWO:   regs_r.delay_mode[2]     <= cfg_wdata;
        REG_DELAY_MODE_THREE: regs_r.delay_mode[3]     <= cfg_wdata;
        REG_DELAY_MODE_FOUR:  regs_r.delay_mode[4]     <= cfg_wdata;
        REG_PULSE_TICKS:      regs_r.pulse_ticks       <= cfg_wdata;
        REG_RAMP_START_DELAY: regs_r.ramp_start_delay  <= cfg_wdata;
        REG_RAMP_STEP:        regs_r.ramp_step         <= cfg_wdata;
        default:              regs_r                   <= regs_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pafm_step.sv =====
// Controller state and per-tick next-state logic of the firing block.
`default_nettype none
`include "assert_macros.svh"
module pafm_step
  import pafm_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire in_item_t  item,
  input  wire cfg_regs_t regs,
  output out_item_t      result_nxt
);

  localparam int CW = COUNT_WIDTH;
  localparam int DW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

  logic               on_r, on_nxt;
  logic [MODE_W-1:0]  mode_r, mode_nxt;
  combo_t             combo_r, combo_nxt;
  logic               ramp_act_r, ramp_act_nxt;
  logic [CW-1:0]      ramp_dly_r, ramp_dly_nxt;
  logic               half_high_r, half_high_nxt;
  phase_t             phase_r, phase_nxt;
  logic [CW-1:0]      tick_cnt_r, tick_cnt_nxt;
  logic [CW-1:0]      chosen_r, chosen_nxt;
  logic [BLINK_W-1:0] blink_cnt_r, blink_cnt_nxt;
  logic               blink_lit_r, blink_lit_nxt;
  logic [LED_W-1:0]   led_r, led_nxt;

  always_comb begin
    logic                  watch;
    logic                  crossing;
    logic [CW-1:0]         target;
    logic [CW-1:0]         pulse;
    logic [CW-1:0]         diff;
    logic [CFG_DATA_W-1:0] step;

    on_nxt        = on_r;
    mode_nxt      = mode_r;
    combo_nxt     = combo_r;
    ramp_act_nxt  = ramp_act_r;
    ramp_dly_nxt  = ramp_dly_r;
    half_high_nxt = half_high_r;
    phase_nxt     = phase_r;
    tick_cnt_nxt  = tick_cnt_r;
    chosen_nxt    = chosen_r;
    blink_cnt_nxt = blink_cnt_r;
    blink_lit_nxt = blink_lit_r;
    led_nxt       = led_r;
    watch         = 1'b0;
    crossing      = 1'b0;
    pulse         = CW'(regs.pulse_ticks);
    step          = (regs.ramp_step != '0) ? regs.ramp_step : CFG_DATA_W'(1);

    // Buttons and power.
    if (item.power_held && !on_r) begin
      ramp_act_nxt = 1'b1;
      if (item.plus_held) begin
        combo_nxt = CMB_PLUS;
      end else if (item.minus_held) begin
        combo_nxt = CMB_MINUS;
      end else begin
        on_nxt    = 1'b1;
        mode_nxt  = (combo_r == CMB_PLUS)  ? MODE_MAX :
                    (combo_r == CMB_MINUS) ? MODE_MIN : MODE_START;
        combo_nxt = CMB_NONE;
        watch     = 1'b1;
      end
    end else if (item.power_held && on_r) begin
      if (item.emergency_stop) begin
        ramp_act_nxt = 1'b1;
      end else begin
        if (item.plus_held) begin
          combo_nxt = CMB_PLUS;
        end else if (item.minus_held) begin
          combo_nxt = CMB_MINUS;
        end else begin
          if (combo_r == CMB_PLUS && mode_r < MODE_MAX) begin
            mode_nxt = mode_r + MODE_W'(1);
          end else if (combo_r == CMB_MINUS && mode_r > MODE_MIN) begin
            mode_nxt = mode_r - MODE_W'(1);
          end
          combo_nxt = CMB_NONE;
        end
        led_nxt = mode_leds(mode_nxt);
      end
      watch = 1'b1;
    end else if (!item.power_held && on_r) begin
      on_nxt       = 1'b0;
      led_nxt      = '0;
      phase_nxt    = PH_IDLE;
      tick_cnt_nxt = '0;
    end

    target = CW'(regs.delay_mode[mode_nxt]);
    diff   = ramp_dly_nxt - target;

    if (on_nxt) begin
      if (watch) begin
        if (half_high_r) begin
          crossing = (item.line_sample <= SAMPLE_W'(1));
        end else begin
          crossing = (item.line_sample != '0);
        end
      end

      if (crossing) begin
        half_high_nxt = !half_high_r;
        if (!item.emergency_stop) begin
          phase_nxt    = PH_VPULSE;
          tick_cnt_nxt = pulse;
          if (ramp_act_nxt) begin
            if (ramp_dly_nxt > target) begin
              chosen_nxt = ramp_dly_nxt;
              // Clamp the last ramp step to the mode's delay.
              if (DW'(diff) > DW'(step)) begin
                ramp_dly_nxt = ramp_dly_nxt - CW'(step);
              end else begin
                ramp_dly_nxt = target;
              end
            end else begin
              ramp_dly_nxt = CW'(regs.ramp_start_delay);
              ramp_act_nxt = 1'b0;
            end
          end
        end else begin
          phase_nxt    = PH_EM_DELAY;
          tick_cnt_nxt = CW'(EMERG_DELAY);
          if (blink_cnt_r != '0) begin
            blink_cnt_nxt = blink_cnt_r - BLINK_W'(1);
          end else if (!blink_lit_r) begin
            led_nxt       = mode_leds(mode_nxt);
            blink_lit_nxt = 1'b1;
            blink_cnt_nxt = BLINK_LIT;
          end else begin
            led_nxt       = '0;
            blink_lit_nxt = 1'b0;
            blink_cnt_nxt = BLINK_DARK;
          end
        end
      end else if (phase_r != PH_IDLE) begin
        if (tick_cnt_r > CW'(1)) begin
          tick_cnt_nxt = tick_cnt_r - CW'(1);
        end else begin
          case (phase_r)
            PH_VPULSE: begin
              if (!ramp_act_nxt) begin
                chosen_nxt = target;
              end
              phase_nxt    = PH_DELAY;
              tick_cnt_nxt = chosen_nxt;
            end
            PH_DELAY: begin
              phase_nxt    = PH_GATE;
              tick_cnt_nxt = pulse;
            end
            PH_EM_DELAY: begin
              phase_nxt    = PH_EM_PULSE;
              tick_cnt_nxt = pulse;
            end
            default: begin
              phase_nxt    = PH_IDLE;
              tick_cnt_nxt = '0;
            end
          endcase
        end
      end
    end

    result_nxt.gate_pulse    = (phase_nxt == PH_GATE);
    result_nxt.voltage_pulse = (phase_nxt == PH_VPULSE) || (phase_nxt == PH_EM_PULSE);
    result_nxt.leds_lit      = led_nxt;
    result_nxt.powered_on    = on_nxt;
    result_nxt.mode_now      = mode_nxt;
    result_nxt.ramping       = ramp_act_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r        <= 1'b0;
      mode_r      <= MODE_MIN;
      combo_r     <= CMB_NONE;
      ramp_act_r  <= 1'b0;
      ramp_dly_r  <= CW'(RAMP_START_RESET);
      half_high_r <= 1'b0;
      phase_r     <= PH_IDLE;
      tick_cnt_r  <= '0;
      chosen_r    <= '0;
      blink_cnt_r <= BLINK_DARK;
      blink_lit_r <= 1'b0;
      led_r       <= '0;
    end else if (en) begin
      on_r        <= on_nxt;
      mode_r      <= mode_nxt;
      combo_r     <= combo_nxt;
      ramp_act_r  <= ramp_act_nxt;
      ramp_dly_r  <= ramp_dly_nxt;
      half_high_r <= half_high_nxt;
      phase_r     <= phase_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
      chosen_r    <= chosen_nxt;
      blink_cnt_r <= blink_cnt_nxt;
      blink_lit_r <= blink_lit_nxt;
      led_r       <= led_nxt;
    end
  end

  `PAFM_ASSERT(a_off_means_idle, !on_r |-> (phase_r == PH_IDLE))
  `PAFM_ASSERT(a_mode_in_range, mode_r <= MODE_MAX)
  `PAFM_ASSERT(a_blink_in_range, blink_cnt_r <= BLINK_DARK)
  `PAFM_ASSERT(a_hold_when_stalled, !en |=> $stable(phase_r) && $stable(tick_cnt_r))

endmodule
`default_nettype wire

// ===== rtl/phase_angle_motor_firing.sv =====
// Phase-angle motor firing controller, top level.
// Path: an accepted transaction goes through the input register, then the next-state logic
// into the result register, from which it is offered.
// Throughput: one transaction per cycle; the result register drains in the
// same cycle it refills, so the input stalls only while out_ready is low.
// Reset: synchronous on rst_n low; controller off, registers at defaults.
`default_nettype none
`include "assert_macros.svh"
module phase_angle_motor_firing
  import pafm_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  in_item_t  in_r;
  logic      in_vld_r, in_vld_nxt;
  out_item_t out_r;
  logic      out_vld_r, out_vld_nxt;
  out_item_t result_nxt;
  cfg_regs_t regs;
  logic      advance;

  // Move the held transaction into the result register when it has room.
  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  assign in_vld_nxt  = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : in_vld_r);
  assign out_vld_nxt = advance ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);

  pafm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  pafm_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (advance),
    .item       (in_r),
    .regs       (regs),
    .result_nxt (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= result_nxt;
    end
  end

  `PAFM_ASSERT(a_advance_fills_out, advance |=> out_vld_r)
  `PAFM_ASSERT(a_stall_keeps_item, (in_vld_r && out_vld_r && !out_ready) |=> in_vld_r)
  `PAFM_ASSERT(a_pulses_exclusive, out_vld_r |-> !(out_r.gate_pulse && out_r.voltage_pulse))
  `PAFM_ASSERT(a_off_all_dark,
               (out_vld_r && !out_r.powered_on) |-> (out_r.leds_lit == '0) && !out_r.gate_pulse)

endmodule
`default_nettype wire

// ===== bench/tb_phase_angle_motor_firing.sv =====
// Self-checking testbench for the phase-angle motor firing controller.
`timescale 1ns / 100ps
module tb_phase_angle_motor_firing
  import pafm_pkg::*;
();

  localparam int DIR_ROWS    = 25;
  localparam int CYCLE_LIMIT = 6000000;

  typedef enum int {SEG_RUN, SEG_EMERG, SEG_OFF, SEG_NOISE} seg_kind_t;
  typedef enum int {SET_SMALL, SET_ZERO, SET_MAX, SET_LOW_RAMP} setting_t;

  typedef struct packed {
    in_item_t  stim;
    logic      typed;
    out_item_t res;
  } dir_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Controller model state
  logic [CFG_DATA_W-1:0] regs_q [8];
  logic on_q = 1'b0;
  logic [MODE_W-1:0] mode_q = '0;
  combo_t combo_q = CMB_NONE;
  logic ramp_on_q = 1'b0;
  logic [CFG_DATA_W-1:0] ramp_dly_q = RAMP_START_RESET;
  logic half_hi_q = 1'b0;
  phase_t ph_q = PH_IDLE;
  logic [CFG_DATA_W-1:0] tick_q = '0;
  logic [CFG_DATA_W-1:0] chosen_q = '0;
  logic [BLINK_W-1:0] blink_cnt_q = BLINK_DARK;
  logic blink_lit_q = 1'b0;
  logic [LED_W-1:0] led_q = '0;

  out_item_t expected_firing [$];
  dir_row_t dir_tab [DIR_ROWS];
  int fail_count = 0;
  int cycle_count;
  int stall_left = 0;
  bit calm = 1'b0;

  // Random line and button pattern state
  seg_kind_t seg_kind = SEG_RUN;
  int seg_left = 0;
  int half_left = 0;
  int wave_max = 1;
  int btn_left = 0;
  int btn_sel = 0;
  bit wave_hi = 1'b0;

  phase_angle_motor_firing dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [LED_W-1:0] lit_pattern(input logic [MODE_W-1:0] m);
    int k;
    k = (m > MODE_MAX) ? 4 : int'(m);
    return LED_W'((1 << (k + 1)) - 1);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] firing_delay();
    int k;
    k = (mode_q > MODE_MAX) ? 4 : int'(mode_q);
    return regs_q[k];
  endfunction

  task automatic predict_firing(input in_item_t it, output out_item_t res);
    logic watch;
    logic crossed;
    logic [CFG_DATA_W-1:0] target;
    logic [CFG_DATA_W-1:0] step;
    watch = 1'b0;
    crossed = 1'b0;
    if (it.power_held && !on_q) begin
      ramp_on_q = 1'b1;
      if (it.plus_held) begin
        combo_q = CMB_PLUS;
      end else if (it.minus_held) begin
        combo_q = CMB_MINUS;
      end else begin
        on_q = 1'b1;
        mode_q = (combo_q == CMB_PLUS) ? MODE_MAX :
                 (combo_q == CMB_MINUS) ? MODE_MIN : MODE_START;
        combo_q = CMB_NONE;
        watch = 1'b1;
      end
    end else if (it.power_held && on_q) begin
      // Emergency ignores the buttons and re-arms the soft start.
      if (it.emergency_stop) begin
        ramp_on_q = 1'b1;
      end else begin
        if (it.plus_held) begin
          combo_q = CMB_PLUS;
        end else if (it.minus_held) begin
          combo_q = CMB_MINUS;
        end else begin
          if (combo_q == CMB_PLUS && mode_q < MODE_MAX) mode_q = mode_q + 3'd1;
          else if (combo_q == CMB_MINUS && mode_q > MODE_MIN) mode_q = mode_q - 3'd1;
          combo_q = CMB_NONE;
        end
        led_q = lit_pattern(mode_q);
      end
      watch = 1'b1;
    end else if (!it.power_held && on_q) begin
      on_q = 1'b0;
      led_q = '0;
      ph_q = PH_IDLE;
      tick_q = '0;
    end

    if (on_q) begin
      if (watch) begin
        if (it.line_sample <= 1 && half_hi_q) begin
          half_hi_q = 1'b0;
          crossed = 1'b1;
        end else if (it.line_sample >= 1 && !half_hi_q) begin
          half_hi_q = 1'b1;
          crossed = 1'b1;
        end
      end
      if (crossed && !it.emergency_stop) begin
        target = firing_delay();
        ph_q = PH_VPULSE;
        tick_q = regs_q[REG_PULSE_TICKS];
        if (ramp_on_q) begin
          if (ramp_dly_q > target) begin
            step = (regs_q[REG_RAMP_STEP] != 0) ? regs_q[REG_RAMP_STEP] : 16'd1;
            chosen_q = ramp_dly_q;
            // Clamp the last step to the target.
            if (ramp_dly_q - target > step) ramp_dly_q = ramp_dly_q - step;
            else ramp_dly_q = target;
          end else begin
            ramp_dly_q = regs_q[REG_RAMP_START_DELAY];
            ramp_on_q = 1'b0;
          end
        end
      end else if (crossed) begin
        ph_q = PH_EM_DELAY;
        tick_q = EMERG_DELAY;
        if (blink_cnt_q != 0) begin
          blink_cnt_q = blink_cnt_q - 7'd1;
        end else if (!blink_lit_q) begin
          led_q = lit_pattern(mode_q);
          blink_lit_q = 1'b1;
          blink_cnt_q = BLINK_LIT;
        end else begin
          led_q = '0;
          blink_lit_q = 1'b0;
          blink_cnt_q = BLINK_DARK;
        end
      end else if (ph_q != PH_IDLE) begin
        // A loaded count of zero still lasts one tick.
        if (tick_q > 16'd1) begin
          tick_q = tick_q - 16'd1;
        end else begin
          case (ph_q)
            PH_VPULSE: begin
              if (!ramp_on_q) chosen_q = firing_delay();
              ph_q = PH_DELAY;
              tick_q = chosen_q;
            end
            PH_DELAY: begin
              ph_q = PH_GATE;
              tick_q = regs_q[REG_PULSE_TICKS];
            end
            PH_EM_DELAY: begin
              ph_q = PH_EM_PULSE;
              tick_q = regs_q[REG_PULSE_TICKS];
            end
            default: begin
              ph_q = PH_IDLE;
              tick_q = '0;
            end
          endcase
        end
      end
    end

    res.gate_pulse    = (ph_q == PH_GATE);
    res.voltage_pulse = (ph_q == PH_VPULSE) || (ph_q == PH_EM_PULSE);
    res.leds_lit      = led_q;
    res.powered_on    = on_q;
    res.mode_now      = mode_q;
    res.ramping       = ramp_on_q;
  endtask

  task automatic send_tick(input in_item_t it, input logic typed, input out_item_t typed_res,
                           input int gap);
    out_item_t res;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_firing(it, res);
    expected_firing.push_back(typed ? typed_res : res);
  endtask

  // Drain the pipeline, then rewrite every register.
  task automatic program_regs(input setting_t s);
    logic [7:0][CFG_DATA_W-1:0] vals;
    int i;
    in_valid <= 1'b0;
    while (expected_firing.size() != 0) @(posedge clk);
    case (s)
      SET_ZERO: vals = '0;
      SET_MAX:  vals = '1;
      SET_LOW_RAMP: begin
        for (i = 0; i < NUM_MODES; i++) vals[i] = 16'($urandom_range(30, 60));
        vals[REG_PULSE_TICKS]      = 16'($urandom_range(1, 4));
        vals[REG_RAMP_START_DELAY] = 16'($urandom_range(0, 25));
        vals[REG_RAMP_STEP] = $urandom_range(0, 1) ? 16'($urandom()) :
                                                     16'($urandom_range(1, 8));
      end
      default: begin
        for (i = 0; i < NUM_MODES; i++) vals[i] = 16'($urandom_range(0, 40));
        vals[REG_PULSE_TICKS]      = 16'($urandom_range(1, 6));
        vals[REG_RAMP_START_DELAY] = 16'($urandom_range(20, 150));
        vals[REG_RAMP_STEP]        = 16'($urandom_range(1, 25));
      end
    endcase
    for (i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      regs_q[i] = vals[i];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic next_item(output in_item_t it);
    int r;
    logic press;
    if (seg_left == 0) begin
      r = $urandom_range(0, 99);
      seg_kind = (r < 55) ? SEG_RUN : (r < 70) ? SEG_EMERG : (r < 82) ? SEG_OFF : SEG_NOISE;
      seg_left = $urandom_range(5, 80);
      calm = ($urandom_range(0, 4) == 0);
      wave_max = $urandom_range(1, 40);
      if (seg_kind == SEG_EMERG) begin
        // Cross often so the blink count runs through.
        wave_max = $urandom_range(1, 3);
        seg_left = $urandom_range(20, 160);
      end
      if (seg_kind == SEG_RUN && $urandom_range(0, 2) == 0) begin
        btn_left = $urandom_range(1, 3);
        btn_sel  = $urandom_range(0, 2);
      end
    end
    seg_left--;
    it = '0;
    case (seg_kind)
      SEG_NOISE: begin
        it.power_held     = 1'($urandom_range(0, 1));
        it.plus_held      = 1'($urandom_range(0, 1));
        it.minus_held     = 1'($urandom_range(0, 1));
        it.emergency_stop = 1'($urandom_range(0, 1));
        it.line_sample    = SAMPLE_W'($urandom_range(0, 1023));
      end
      SEG_OFF: begin
        it.plus_held      = 1'($urandom_range(0, 1));
        it.minus_held     = 1'($urandom_range(0, 1));
        it.emergency_stop = 1'($urandom_range(0, 1));
        it.line_sample    = SAMPLE_W'($urandom_range(0, 1023));
      end
      default: begin
        if (btn_left == 0 && $urandom_range(0, 19) == 0) begin
          btn_left = $urandom_range(1, 4);
          btn_sel  = $urandom_range(0, 2);
        end
        press = (btn_left != 0);
        if (press) btn_left--;
        if (half_left == 0) begin
          wave_hi = !wave_hi;
          half_left = $urandom_range(1, wave_max);
        end
        half_left--;
        it.power_held     = 1'b1;
        it.plus_held      = press && (btn_sel != 1);
        it.minus_held     = press && (btn_sel != 0);
        it.emergency_stop = (seg_kind == SEG_EMERG) || ($urandom_range(0, 99) == 0);
        if (wave_hi) it.line_sample = SAMPLE_W'($urandom_range(2, 1023));
        else it.line_sample = ($urandom_range(0, 7) == 0) ? 10'd1 : 10'd0;
      end
    endcase
  endtask

  task automatic run_random(input int n);
    in_item_t it;
    int k;
    for (k = 0; k < n; k++) begin
      next_item(it);
      send_tick(it, 1'b0, '0, calm ? 0 : idle_len());
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 7) == 0) stall_left <= idle_len();
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_firing.size() == 0) begin
        $error("result transaction with nothing expected");
        fail_count++;
      end else begin
        want = expected_firing.pop_front();
        if (out_data.gate_pulse !== want.gate_pulse) begin
          $error("gate_pulse: expected %0d, got %0d", want.gate_pulse, out_data.gate_pulse);
          fail_count++;
        end
        if (out_data.voltage_pulse !== want.voltage_pulse) begin
          $error("voltage_pulse: expected %0d, got %0d", want.voltage_pulse,
                 out_data.voltage_pulse);
          fail_count++;
        end
        if (out_data.leds_lit !== want.leds_lit) begin
          $error("leds_lit: expected %b, got %b", want.leds_lit, out_data.leds_lit);
          fail_count++;
        end
        if (out_data.powered_on !== want.powered_on) begin
          $error("powered_on: expected %0d, got %0d", want.powered_on, out_data.powered_on);
          fail_count++;
        end
        if (out_data.mode_now !== want.mode_now) begin
          $error("mode_now: expected %0d, got %0d", want.mode_now, out_data.mode_now);
          fail_count++;
        end
        if (out_data.ramping !== want.ramping) begin
          $error("ramping: expected %0d, got %0d", want.ramping, out_data.ramping);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_phase_angle_motor_firing: done, errors");
    $finish;
  end

  initial begin : stimulus
    int k;
    for (k = 0; k < NUM_MODES; k++) regs_q[k] = DELAY_RESET[k];
    regs_q[REG_PULSE_TICKS]      = PULSE_RESET;
    regs_q[REG_RAMP_START_DELAY] = RAMP_START_RESET;
    regs_q[REG_RAMP_STEP]        = RAMP_STEP_RESET;

    // Buttons as {power, plus, minus, emergency}, then the line sample.
    dir_tab[0]  = {4'b0000, 10'd0,    1'b1, 12'b0};
    dir_tab[1]  = {4'b1000, 10'd0,    1'b1, 1'b0, 1'b0, 5'd0, 1'b1, 3'd2, 1'b1};
    dir_tab[2]  = {4'b1000, 10'd1023, 1'b1, 1'b0, 1'b1, 5'd7, 1'b1, 3'd2, 1'b1};
    dir_tab[3]  = {4'b1000, 10'd1,    1'b0, 12'b0};  // a sample of one crosses each tick
    dir_tab[4]  = {4'b1000, 10'd1,    1'b0, 12'b0};
    dir_tab[5]  = {4'b1000, 10'd0,    1'b0, 12'b0};
    dir_tab[6]  = {4'b1100, 10'd512,  1'b0, 12'b0};
    dir_tab[7]  = {4'b1000, 10'd0,    1'b0, 12'b0};
    dir_tab[8]  = {4'b1100, 10'd1023, 1'b0, 12'b0};
    dir_tab[9]  = {4'b1000, 10'd0,    1'b0, 12'b0};
    dir_tab[10] = {4'b1100, 10'd700,  1'b0, 12'b0};
    dir_tab[11] = {4'b1000, 10'd0,    1'b0, 12'b0};  // saturate at the top mode
    dir_tab[12] = {4'b1010, 10'd1023, 1'b0, 12'b0};
    dir_tab[13] = {4'b1000, 10'd0,    1'b0, 12'b0};
    dir_tab[14] = {4'b1111, 10'd1023, 1'b0, 12'b0};  // emergency ignores buttons
    dir_tab[15] = {4'b1001, 10'd0,    1'b0, 12'b0};
    dir_tab[16] = {4'b0000, 10'd512,  1'b0, 12'b0};
    dir_tab[17] = {4'b1100, 10'd0,    1'b0, 12'b0};  // start in the top mode
    dir_tab[18] = {4'b1000, 10'd1023, 1'b0, 12'b0};
    dir_tab[19] = {4'b0111, 10'd1023, 1'b0, 12'b0};
    dir_tab[20] = {4'b1010, 10'd0,    1'b0, 12'b0};  // start in the bottom mode
    dir_tab[21] = {4'b1000, 10'd0,    1'b0, 12'b0};
    dir_tab[22] = {4'b1010, 10'd1023, 1'b0, 12'b0};
    dir_tab[23] = {4'b1000, 10'd0,    1'b0, 12'b0};  // saturate at the bottom mode
    dir_tab[24] = {4'b1001, 10'd1,    1'b0, 12'b0};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DIR_ROWS; k++)
      send_tick(dir_tab[k].stim, dir_tab[k].typed, dir_tab[k].res, idle_len());

    program_regs(SET_SMALL);
    run_random(350);
    program_regs(SET_ZERO);
    run_random(250);
    program_regs(SET_MAX);
    run_random(100);
    program_regs(SET_LOW_RAMP);
    run_random(300);

    program_regs(SET_SMALL);
    run_random(150);

    program_regs(SET_SMALL);
    run_random(300);

    in_valid <= 1'b0;
    while (expected_firing.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_phase_angle_motor_firing: done, clean");
    end else begin
      $display("tb_phase_angle_motor_firing: done, errors");
    end
    $finish;
  end

endmodule
